// ===== rtl/dq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes of the double-ended queue
// Request codes, result status codes and the command beat that passes from
// the front part to the back part through the command queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int ActionW    = 3;
  localparam int ValueW     = 32;
  localparam int CountOutW  = 5;
  localparam int StatusW    = 2;
  // a dump never gives more results than this
  localparam int MaxResults = 16;

  // request codes as they arrive on the action port
  typedef enum logic [ActionW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP_FWD   = 3'd4,
    OP_DUMP_BWD   = 3'd5,
    OP_COUNT      = 3'd6
  } dq_op_e;

  // the one code that carries no request
  localparam logic [ActionW-1:0] ActUnused = 3'd7;

  // result status codes
  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;

  // one classified request
  typedef struct packed {
    dq_op_e                   op;
    logic signed [ValueW-1:0] value;
  } dq_cmd_t;

  // command queue status seen by the front part
  typedef struct packed {
    logic full;
    logic empty;
  } dq_fifo_stat_t;

endpackage
`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
// Ring store of DEPTH entries with push and pop at either end, dumps and
// a count request, behind a two-entry command queue.
// ----------------------------------------------------------------------------
// A request beat is taken on a rising edge with start_i high and busy_o low.
// With the back part idle, its first result passes the command queue and
// the result registers and shows on the result ports, marked by done_o for
// one cycle; results cannot be held off and must be taken as they come.
// Push, pop and count never stall the back part, so one request a cycle
// is sustained while no dump runs. A dump walks the ring one entry a cycle
// through the single read port of the store, giving min(count, 16) results
// on consecutive cycles, the final one with last_o set. While a dump runs,
// up to two further requests wait in the command queue and busy_o rises
// once both slots are taken. Action code 7 is taken and gives no result.
// Store entries need no clearing after reset.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [dq_pkg::ActionW-1:0]       action_i,
  input  logic signed [dq_pkg::ValueW-1:0] push_value_i,
  output logic                             done_o,
  output logic signed [dq_pkg::ValueW-1:0] item_value_o,
  output logic [dq_pkg::CountOutW-1:0]     entry_count_o,
  output logic [dq_pkg::StatusW-1:0]       status_o,
  output logic                             last_o
);
  import dq_pkg::*;

  dq_fifo_stat_t fifo_stat;
  dq_cmd_t       front_cmd;
  dq_cmd_t       back_cmd;
  logic          front_push;
  logic          back_valid;
  logic          back_pop;

  // intake and classification
  dq_front u_front (
    .start_i      (start_i),
    .action_i     (action_i),
    .push_value_i (push_value_i),
    .fifo_stat_i  (fifo_stat),
    .busy_o       (busy_o),
    .push_o       (front_push),
    .cmd_o        (front_cmd)
  );

  // command queue between the two parts
  dq_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .cmd_i   (front_cmd),
    .pop_i   (back_pop),
    .cmd_o   (back_cmd),
    .valid_o (back_valid),
    .stat_o  (fifo_stat)
  );

  // execution against the ring store
  dq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (back_valid),
    .cmd_i         (back_cmd),
    .cmd_pop_o     (back_pop),
    .done_o        (done_o),
    .item_value_o  (item_value_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

// ===== rtl/dq_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_front: request intake
// Takes request beats while the command queue has room, drops the unused
// action code and hands every real request on as a command beat.
// ----------------------------------------------------------------------------
module dq_front (
  input  logic                             start_i,
  input  logic [dq_pkg::ActionW-1:0]       action_i,
  input  logic signed [dq_pkg::ValueW-1:0] push_value_i,
  input  dq_pkg::dq_fifo_stat_t            fifo_stat_i,
  output logic                             busy_o,
  output logic                             push_o,
  output dq_pkg::dq_cmd_t                  cmd_o
);
  import dq_pkg::*;

  logic accept;
  logic is_real;

  // a beat is taken whenever the queue has room
  assign busy_o  = fifo_stat_i.full;
  assign accept  = start_i && !fifo_stat_i.full;
  assign is_real = (action_i != ActUnused);

  // unused code is swallowed here and never reaches the back part
  assign push_o      = accept && is_real;
  assign cmd_o.op    = dq_op_e'(action_i);
  assign cmd_o.value = push_value_i;

endmodule
`default_nettype wire

// ===== rtl/dq_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_cmd_fifo: two-entry command queue
// Decouples request intake from execution so a long dump does not stall
// the requester until both slots are taken.
// ----------------------------------------------------------------------------
module dq_cmd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dq_pkg::dq_cmd_t       cmd_i,
  input  logic                  pop_i,
  output dq_pkg::dq_cmd_t       cmd_o,
  output logic                  valid_o,
  output dq_pkg::dq_fifo_stat_t stat_o
);
  import dq_pkg::*;

  dq_cmd_t    slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign stat_o.full  = (fill_q == 2'd2);
  assign stat_o.empty = (fill_q == 2'd0);
  assign valid_o      = !stat_o.empty;
  assign cmd_o        = slot_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // payload slots, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dq_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_back: ring store and request execution
// Holds the ring memory, front index and fill count, carries out one
// command a cycle when idle and walks the ring one entry a cycle in a dump.
// ----------------------------------------------------------------------------
module dq_back #(
  parameter int DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  input  dq_pkg::dq_cmd_t                     cmd_i,
  output logic                                cmd_pop_o,
  output logic                                done_o,
  output logic signed [dq_pkg::ValueW-1:0]    item_value_o,
  output logic [dq_pkg::CountOutW-1:0]        entry_count_o,
  output logic [dq_pkg::StatusW-1:0]          status_o,
  output logic                                last_o
);
  import dq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = $clog2(MaxResults + 1);

  localparam logic StIdle = 1'b0;
  localparam logic StDump = 1'b1;

  // next ring place, forward or backward
  function automatic logic [IW-1:0] ring_step(input logic [IW-1:0] p, input logic bwd);
    logic [IW-1:0] r;
    if (bwd) begin
      r = (p == '0) ? IW'(DEPTH - 1) : p - 1'b1;
    end else begin
      r = (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
    end
    return r;
  endfunction

  // (a + b) mod DEPTH for a, b below DEPTH
  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IW+1)'(DEPTH)) begin
      s = s - (IW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  logic                state_q, state_d;
  logic [IW-1:0]       front_q, front_d;
  logic [CW-1:0]       count_q, count_d;
  logic [IW-1:0]       ptr_q, ptr_d;
  logic [LW-1:0]       left_q, left_d;
  logic                dir_q, dir_d;

  logic [ValueW-1:0]   mem_q [DEPTH];
  logic [ValueW-1:0]   rdata_q;
  logic                wr_en, rd_en;
  logic [IW-1:0]       wr_addr, rd_addr;

  logic                res_valid_q, res_valid_d;
  logic                res_mem_q, res_mem_d;
  logic [CountOutW-1:0] res_count_q;
  logic [StatusW-1:0]  res_status_q, res_status_d;
  logic                res_last_q, res_last_d;

  logic                full, empty;
  logic [IW-1:0]       back_pos;
  logic [IW-1:0]       start_pos;
  logic                dump_bwd;
  logic [LW-1:0]       dump_len;

  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign back_pos = ring_add(front_q, IW'(count_q - 1'b1));
  assign dump_bwd = (cmd_i.op == OP_DUMP_BWD);
  assign start_pos = dump_bwd ? back_pos : front_q;
  // dump length is the fill count capped at the result limit
  assign dump_len = ({{(32-CW){1'b0}}, count_q} > 32'(MaxResults)) ?
                    LW'(MaxResults) : LW'(count_q);

  // command execution and dump walk
  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    left_d       = left_q;
    dir_d        = dir_q;
    wr_en        = 1'b0;
    wr_addr      = front_q;
    rd_en        = 1'b0;
    rd_addr      = front_q;
    cmd_pop_o    = 1'b0;
    res_valid_d  = 1'b0;
    res_mem_d    = 1'b0;
    res_status_d = StOk;
    res_last_d   = 1'b1;

    if (state_q == StDump) begin
      rd_en       = 1'b1;
      rd_addr     = ptr_q;
      ptr_d       = ring_step(ptr_q, dir_q);
      left_d      = left_q - 1'b1;
      res_valid_d = 1'b1;
      res_mem_d   = 1'b1;
      res_last_d  = (left_q == LW'(1));
      if (left_q == LW'(1)) begin
        state_d = StIdle;
      end
    end else if (cmd_valid_i) begin
      cmd_pop_o   = 1'b1;
      res_valid_d = 1'b1;
      case (cmd_i.op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) begin
            res_status_d = StFull;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + 1'b1;
            if (cmd_i.op == OP_PUSH_FRONT) begin
              front_d = ring_step(front_q, 1'b1);
              wr_addr = front_d;
            end else begin
              wr_addr = ring_add(front_q, IW'(count_q));
            end
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (empty) begin
            res_status_d = StEmpty;
          end else begin
            rd_en     = 1'b1;
            res_mem_d = 1'b1;
            count_d   = count_q - 1'b1;
            if (cmd_i.op == OP_POP_FRONT) begin
              rd_addr = front_q;
              front_d = ring_step(front_q, 1'b0);
            end else begin
              rd_addr = back_pos;
            end
          end
        end
        OP_DUMP_FWD, OP_DUMP_BWD: begin
          if (empty) begin
            res_status_d = StEmpty;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = start_pos;
            res_mem_d  = 1'b1;
            res_last_d = (dump_len == LW'(1));
            if (dump_len != LW'(1)) begin
              state_d = StDump;
              ptr_d   = ring_step(start_pos, dump_bwd);
              left_d  = dump_len - 1'b1;
              dir_d   = dump_bwd;
            end
          end
        end
        OP_COUNT: begin
          res_status_d = StOk;
        end
        default: begin
          res_valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      front_q     <= '0;
      count_q     <= '0;
      ptr_q       <= '0;
      left_q      <= '0;
      dir_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      left_q      <= left_d;
      dir_q       <= dir_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    res_mem_q    <= res_mem_d;
    res_count_q  <= CountOutW'(count_d);
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  // ring memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= cmd_i.value;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign done_o        = res_valid_q;
  assign item_value_o  = res_mem_q ? rdata_q : '0;
  assign entry_count_o = res_count_q;
  assign status_o      = res_status_q;
  assign last_o        = res_last_q;

endmodule
`default_nettype wire

// ===== rtl/dq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_checker: port-level checks of the double-ended queue
// Watches the result ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module dq_checker #(
  parameter int DEPTH = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic                             done_o,
  input logic signed [dq_pkg::ValueW-1:0] item_value_o,
  input logic [dq_pkg::CountOutW-1:0]     entry_count_o,
  input logic [dq_pkg::StatusW-1:0]       status_o,
  input logic                             last_o
);
  import dq_pkg::*;

  // an empty answer is a single closing beat with nothing in it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == StEmpty |->
      entry_count_o == '0 && last_o && item_value_o == '0)
  else $error("empty result beat malformed");

  // a dropped push only happens with the store full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == StFull |->
      entry_count_o == CountOutW'(DEPTH) && last_o && item_value_o == '0)
  else $error("full result beat malformed");

  // dump beats come back to back until the closing beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |=> done_o && status_o == StOk)
  else $error("dump run broken");

  // nothing comes out until a request has been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !$past(done_o) |-> $past(start_i && !busy_o, 2) || $past(busy_o, 2)
      || $past(done_o, 2) || $past(start_i && !busy_o, 3) || $past(busy_o, 3))
  else $error("result beat without a request");

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH (DEPTH)
) u_dq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .item_value_o  (item_value_o),
  .entry_count_o (entry_count_o),
  .status_o      (status_o),
  .last_o        (last_o)
);
`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for double_ended_queue
// Request beats come from a queue that the stimulus process fills. A clocked
// driver offers them under start/busy with random sender gaps. A shadow deque
// works out every result that each accepted beat should cause. A clocked
// monitor takes each done_o beat and checks it, field by field, against the
// oldest awaited result.
// ----------------------------------------------------------------------------
module tb;
  import dq_pkg::*;

  localparam int QDepth    = 16;
  localparam int TailWait  = 40;
  localparam int RunLimit  = 2000000;

  // one request beat as offered on the ports
  typedef struct packed {
    logic [ActionW-1:0]       action;
    logic signed [ValueW-1:0] value;
  } dq_request_t;

  // one result beat as it should appear on the ports
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [CountOutW-1:0]     count;
    logic [StatusW-1:0]       status;
    logic                     last;
  } dq_result_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     start_i      = 1'b0;
  logic [ActionW-1:0]       action_i     = ActUnused;
  logic signed [ValueW-1:0] push_value_i = '0;
  logic                     busy_o;
  logic                     done_o;
  logic signed [ValueW-1:0] item_value_o;
  logic [CountOutW-1:0]     entry_count_o;
  logic [StatusW-1:0]       status_o;
  logic                     last_o;

  dq_request_t request_queue[$];
  dq_result_t  awaited_results[$];
  int          send_idle_pct = 7;
  int          error_count   = 0;

  // shadow of the deque
  logic signed [ValueW-1:0] shadow_store[QDepth];
  int                       shadow_front = 0;
  int                       shadow_held  = 0;

  double_ended_queue #(.DEPTH(QDepth)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .push_value_i  (push_value_i),
    .done_o        (done_o),
    .item_value_o  (item_value_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  // note one awaited result, count taken after the request
  task automatic await_result(input logic signed [ValueW-1:0] value,
                              input logic [StatusW-1:0] status, input logic last);
    dq_result_t r;
    r.value  = value;
    r.count  = shadow_held[CountOutW-1:0];
    r.status = status;
    r.last   = last;
    awaited_results.push_back(r);
  endtask

  // apply one accepted request to the shadow deque and note its results
  task automatic deque_apply(input dq_request_t req);
    int n;
    int off;
    case (req.action)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_held >= QDepth) begin
          await_result('0, StFull, 1'b1);
        end else begin
          if (req.action == OP_PUSH_FRONT) begin
            shadow_front = (shadow_front + QDepth - 1) % QDepth;
            shadow_store[shadow_front] = req.value;
          end else begin
            shadow_store[(shadow_front + shadow_held) % QDepth] = req.value;
          end
          shadow_held++;
          await_result('0, StOk, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_held == 0) begin
          await_result('0, StEmpty, 1'b1);
        end else if (req.action == OP_POP_FRONT) begin
          off = shadow_front;
          shadow_front = (shadow_front + 1) % QDepth;
          shadow_held--;
          await_result(shadow_store[off], StOk, 1'b1);
        end else begin
          shadow_held--;
          await_result(shadow_store[(shadow_front + shadow_held) % QDepth], StOk, 1'b1);
        end
      end
      OP_DUMP_FWD, OP_DUMP_BWD: begin
        if (shadow_held == 0) begin
          await_result('0, StEmpty, 1'b1);
        end else begin
          n = (shadow_held > MaxResults) ? MaxResults : shadow_held;
          for (int i = 0; i < n; i++) begin
            off = (req.action == OP_DUMP_FWD) ? i : shadow_held - 1 - i;
            await_result(shadow_store[(shadow_front + off) % QDepth], StOk, i == n - 1);
          end
        end
      end
      OP_COUNT: await_result('0, StOk, 1'b1);
      default: ; // unused code: taken, no result
    endcase
  endtask

  // driver: offer the oldest pending beat, with random sender gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i      <= 1'b0;
      action_i     <= ActUnused;
      push_value_i <= '0;
    end else begin
      if (start_i && !busy_o) begin
        deque_apply(request_queue.pop_front());
      end
      // a beat held off by busy stays on the ports
      if (!(start_i && busy_o)) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          start_i      <= 1'b1;
          action_i     <= request_queue[0].action;
          push_value_i <= request_queue[0].value;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string name, input logic [ValueW-1:0] want,
                              input logic [ValueW-1:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    error_count++;
  endtask

  // monitor: every done beat must match the oldest awaited result
  always @(posedge clk_i) begin : monitor
    dq_result_t want;
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0h count %0d",
                 $time, item_value_o, entry_count_o);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (item_value_o !== want.value)
          report_field("item_value", want.value, item_value_o);
        if (entry_count_o !== want.count)
          report_field("entry_count", ValueW'(want.count), ValueW'(entry_count_o));
        if (status_o !== want.status)
          report_field("status", ValueW'(want.status), ValueW'(status_o));
        if (last_o !== want.last)
          report_field("last", ValueW'(want.last), ValueW'(last_o));
      end
    end
  end

  task automatic add_request(input logic [ActionW-1:0] action,
                             input logic signed [ValueW-1:0] value);
    dq_request_t r;
    r.action = action;
    r.value  = value;
    request_queue.push_back(r);
  endtask

  // push data: random half the time, else an extreme, zero or minus one
  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return ValueW'($urandom);
    endcase
  endfunction

  // random part of one phase: fill runs, drain runs and mixed runs
  task automatic add_random_phase(input int target);
    int issued;
    int k;
    int kind;
    logic [ActionW-1:0] act;
    issued = 0;
    while (issued < target) begin
      kind = $urandom_range(9);
      if (kind < 3) begin
        // fill run, often past full, then a dump
        k = $urandom_range(10, 20);
        for (int i = 0; i < k; i++)
          add_request(ActionW'($urandom_range(OP_PUSH_FRONT, OP_PUSH_BACK)), pick_value());
        add_request(ActionW'($urandom_range(OP_DUMP_FWD, OP_DUMP_BWD)), pick_value());
        issued += k + 1;
      end else if (kind < 5) begin
        // drain run, often past empty
        k = $urandom_range(8, 20);
        for (int i = 0; i < k; i++)
          add_request(ActionW'($urandom_range(OP_POP_FRONT, OP_POP_BACK)), pick_value());
        issued += k;
      end else begin
        // mixed run, unused code as noise
        k = $urandom_range(4, 10);
        for (int i = 0; i < k; i++) begin
          act = ActionW'($urandom_range(7));
          add_request(act, pick_value());
          if (act != ActUnused) issued++;
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (request_queue.size() > 0 || awaited_results.size() > 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
  endtask

  // stimulus and end of run
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty cases, extremes, every request, unused code
    add_request(OP_COUNT, '0);
    add_request(OP_POP_FRONT, '0);
    add_request(OP_POP_BACK, '0);
    add_request(OP_DUMP_FWD, '0);
    add_request(OP_DUMP_BWD, '0);
    add_request(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
    add_request(OP_PUSH_BACK, 32'sh8000_0000);
    add_request(OP_PUSH_FRONT, -32'sd1);
    add_request(OP_PUSH_BACK, '0);
    add_request(OP_PUSH_FRONT, 32'sd1);
    add_request(ActUnused, -32'sd1);
    add_request(OP_COUNT, -32'sd1);
    add_request(OP_DUMP_FWD, '0);
    add_request(OP_DUMP_BWD, '0);
    add_request(OP_POP_FRONT, '0);
    add_request(OP_POP_BACK, '0);
    add_request(OP_DUMP_FWD, '0);
    add_request(OP_POP_BACK, '0);
    add_request(OP_POP_FRONT, '0);
    add_request(OP_POP_FRONT, '0);
    add_request(OP_DUMP_BWD, '0);
    add_random_phase(60);
    wait_drained();

    send_idle_pct = 83;
    add_random_phase(75);
    wait_drained();

    send_idle_pct = 0;
    add_random_phase(85);
    wait_drained();

    if (error_count == 0) begin
      $display("** double_ended_queue: PASSED **");
    end else begin
      $display("** double_ended_queue: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RunLimit);
    $display("timeout, %0d results still awaited", awaited_results.size());
    $display("** double_ended_queue: FAILED **");
    $finish;
  end

endmodule
